>>> rtl/core/pbu_pkg.sv
// shared constants, codes and controller/datapath interface types
package pbu_pkg;

   // history ring size in bytes, a power of two from 256 to 65536
   localparam int unsigned HISTORY_BYTES = 65536;
   localparam int unsigned RING_AW       = $clog2(HISTORY_BYTES);
   localparam int unsigned BANK_DEPTH    = HISTORY_BYTES / 4;
   localparam int unsigned BANK_AW       = RING_AW - 2;

   // limit for the distance checks, 17 bits wide to hold distance + 4
   localparam logic [16:0] HIST_LIMIT = 17'(HISTORY_BYTES);

   localparam logic [7:0] ESCAPE_BYTE = 8'hfe;

   // error codes on the result word
   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_DIST   = 2'd1,
      ERR_UNRECV = 2'd2,
      ERR_TRUNC  = 2'd3
   } err_type;

   // what the output register loads
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_LIT,
      OUT_META,
      OUT_RAM
   } out_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        accept;
      logic        clear_track;
      logic        set_marker;
      logic        set_dist_hi;
      logic        set_dist_lo;
      logic        start_copy;
      logic        rd_issue;
      out_sel_type out_sel;
      logic        run_last;
      logic        stream_end;
      err_type     err;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_esc;
      logic dist_err;
      logic len_err;
      logic len_zero;
      logic left_zero;
      logic last_group;
   } dp_stat_type;

endpackage

>>> rtl/core/pbu_ram.sv
// generic single-write single-read ram with registered read data
module pbu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pbu_dp.sv
// datapath: track counters, marker fields, banked history ring, output word register
module pbu_dp (
   input  logic                clock,
   input  logic                reset,
   input  pbu_pkg::dp_cmd_type cmd,
   output pbu_pkg::dp_stat_type stat,
   input  logic [7:0]          req_data_byte,
   output logic [7:0]          rsp_out_byte0,
   output logic [7:0]          rsp_out_byte1,
   output logic [7:0]          rsp_out_byte2,
   output logic [7:0]          rsp_out_byte3,
   output logic [2:0]          rsp_byte_count,
   output logic                rsp_run_last,
   output logic                rsp_stream_end,
   output logic [1:0]          rsp_error_code
);

   import pbu_pkg::*;

   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        marker_ff, marker_in;
   logic [15:0]        dist_ff, dist_in;
   logic [RING_AW-1:0] src_ff, src_in;
   logic [7:0]         left_ff, left_in;
   logic [2:0]         pend_cnt_ff, pend_cnt_in;
   logic [1:0]         pend_rot_ff, pend_rot_in;
   logic [2:0]         grp_cnt;

   logic [7:0] out_byte_ff [4];
   logic [7:0] out_byte_in [4];
   logic [2:0] out_cnt_ff, out_cnt_in;
   logic       out_run_last_ff;
   logic       out_stream_end_ff;
   err_type    out_err_ff;

   logic [7:0] bank_rd_data [4];

   // status toward the controller
   always_comb begin
      stat.is_esc     = (req_data_byte == ESCAPE_BYTE);
      stat.dist_err   = ({16'b0, dist_ff} > marker_ff) ||
                        (({1'b0, dist_ff} + 17'd4) > HIST_LIMIT);
      stat.len_err    = ({9'b0, req_data_byte} > ({1'b0, dist_ff} + 17'd4));
      stat.len_zero   = (req_data_byte == 8'd0);
      stat.left_zero  = (left_ff == 8'd0);
      stat.last_group = (left_ff <= 8'd4);
   end

   // bytes in the group being read
   assign grp_cnt = (left_ff >= 8'd4) ? 3'd4 : left_ff[2:0];

   // four interleaved history banks, bank chosen by the low position bits
   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [RING_AW-1:0] rd_pos;
      logic [1:0]         delta;

      assign delta  = 2'(k) - src_ff[1:0];
      assign rd_pos = src_ff + {{(RING_AW-2){1'b0}}, delta};

      pbu_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (cmd.accept && (pos_ff[1:0] == 2'(k))),
         .wr_addr (pos_ff[RING_AW-1:2]),
         .wr_data (req_data_byte),
         .rd_en   (cmd.rd_issue),
         .rd_addr (rd_pos[RING_AW-1:2]),
         .rd_data (bank_rd_data[k])
      );
   end

   // track counters, marker fields and copy cursor
   always_comb begin
      pos_in      = pos_ff;
      marker_in   = marker_ff;
      dist_in     = dist_ff;
      src_in      = src_ff;
      left_in     = left_ff;
      pend_cnt_in = pend_cnt_ff;
      pend_rot_in = pend_rot_ff;
      if (cmd.accept) begin
         pos_in = pos_ff + 32'd1;
      end
      if (cmd.set_marker) begin
         marker_in = pos_ff;
      end
      if (cmd.set_dist_hi) begin
         dist_in = {req_data_byte, 8'd0};
      end
      if (cmd.set_dist_lo) begin
         dist_in = {dist_ff[15:8], req_data_byte};
      end
      if (cmd.start_copy) begin
         src_in  = marker_ff[RING_AW-1:0] - dist_ff[RING_AW-1:0];
         left_in = req_data_byte;
      end
      if (cmd.rd_issue) begin
         src_in      = src_ff + {{(RING_AW-3){1'b0}}, grp_cnt};
         left_in     = left_ff - {5'd0, grp_cnt};
         pend_cnt_in = grp_cnt;
         pend_rot_in = src_ff[1:0];
      end
      if (cmd.clear_track) begin
         pos_in    = 32'd0;
         marker_in = 32'd0;
         dist_in   = 16'd0;
      end
   end

   // next output word
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         out_byte_in[j] = 8'd0;
      end
      out_cnt_in = 3'd0;
      unique case (cmd.out_sel)
         OUT_LIT: begin
            out_byte_in[0] = req_data_byte;
            out_cnt_in     = 3'd1;
         end
         OUT_RAM: begin
            for (int j = 0; j < 4; j++) begin
               if (3'(j) < pend_cnt_ff) begin
                  out_byte_in[j] = bank_rd_data[pend_rot_ff + 2'(j)];
               end
            end
            out_cnt_in = pend_cnt_ff;
         end
         OUT_META, OUT_NONE: begin
            out_cnt_in = 3'd0;
         end
      endcase
   end

   // counters with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 32'd0;
         marker_ff <= 32'd0;
         dist_ff   <= 16'd0;
         left_ff   <= 8'd0;
      end else begin
         pos_ff    <= pos_in;
         marker_ff <= marker_in;
         dist_ff   <= dist_in;
         left_ff   <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      pend_cnt_ff <= pend_cnt_in;
      pend_rot_ff <= pend_rot_in;
      if (cmd.out_sel != OUT_NONE) begin
         for (int j = 0; j < 4; j++) begin
            out_byte_ff[j] <= out_byte_in[j];
         end
         out_cnt_ff        <= out_cnt_in;
         out_run_last_ff   <= cmd.run_last;
         out_stream_end_ff <= cmd.stream_end;
         out_err_ff        <= cmd.err;
      end
   end

   assign rsp_out_byte0  = out_byte_ff[0];
   assign rsp_out_byte1  = out_byte_ff[1];
   assign rsp_out_byte2  = out_byte_ff[2];
   assign rsp_out_byte3  = out_byte_ff[3];
   assign rsp_byte_count = out_cnt_ff;
   assign rsp_run_last   = out_run_last_ff;
   assign rsp_stream_end = out_stream_end_ff;
   assign rsp_error_code = out_err_ff;

endmodule

>>> rtl/core/pbu_ctrl.sv
// controller: marker parser, copy sequencer and word handshake control
module pbu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_last_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pbu_pkg::dp_stat_type stat,
   output pbu_pkg::dp_cmd_type  cmd
);

   import pbu_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   typedef enum logic [1:0] {
      PH_LIT,
      PH_ESC,
      PH_DHI,
      PH_DLO
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      out_valid_ff, out_valid_in;
   logic      pend_ff, pend_in;
   logic      pend_fin_ff, pend_fin_in;
   logic      pend_end_ff, pend_end_in;
   logic      copy_last_ff, copy_last_in;

   logic      out_free;
   logic      accept;
   logic      lit;
   logic      load_ram;
   err_type   err;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_ready && req_valid;
   assign load_ram  = (state_ff == ST_COPY) && pend_ff && out_free;
   assign rsp_valid = out_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      pend_fin_in  = pend_fin_ff;
      pend_end_in  = pend_end_ff;
      copy_last_in = copy_last_ff;
      lit          = 1'b0;
      err          = ERR_NONE;
      cmd          = '0;
      cmd.out_sel  = OUT_NONE;
      cmd.err      = ERR_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept      = 1'b1;
               cmd.clear_track = req_last_in;
               // marker parse
               unique case (phase_ff)
                  PH_LIT: begin
                     if (stat.is_esc) begin
                        cmd.set_marker = 1'b1;
                        phase_in       = PH_ESC;
                     end else begin
                        lit = 1'b1;
                     end
                  end
                  PH_ESC: begin
                     if (stat.is_esc) begin
                        lit      = 1'b1;
                        phase_in = PH_LIT;
                     end else begin
                        cmd.set_dist_hi = 1'b1;
                        phase_in        = PH_DHI;
                     end
                  end
                  PH_DHI: begin
                     cmd.set_dist_lo = 1'b1;
                     phase_in        = PH_DLO;
                  end
                  PH_DLO: begin
                     phase_in = PH_LIT;
                     if (stat.dist_err) begin
                        err = ERR_DIST;
                     end else if (stat.len_err) begin
                        err = ERR_UNRECV;
                     end else if (!stat.len_zero) begin
                        cmd.start_copy = 1'b1;
                        state_in       = ST_COPY;
                        copy_last_in   = req_last_in;
                     end
                  end
               endcase
               if (req_last_in && (phase_in != PH_LIT)) begin
                  err = ERR_TRUNC;
               end
               // result word for this byte
               if (err != ERR_NONE) begin
                  cmd.out_sel    = OUT_META;
                  cmd.err        = err;
                  cmd.run_last   = 1'b1;
                  cmd.stream_end = req_last_in;
               end else if (lit) begin
                  cmd.out_sel    = OUT_LIT;
                  cmd.run_last   = 1'b1;
                  cmd.stream_end = req_last_in;
               end else if (req_last_in && !cmd.start_copy) begin
                  cmd.out_sel    = OUT_META;
                  cmd.run_last   = 1'b1;
                  cmd.stream_end = 1'b1;
               end
               if (req_last_in) begin
                  phase_in = PH_LIT;
               end
            end
         end
         ST_COPY: begin
            // read stage feeds the output register
            if (load_ram) begin
               cmd.out_sel    = OUT_RAM;
               cmd.run_last   = pend_fin_ff;
               cmd.stream_end = pend_end_ff;
               pend_in        = 1'b0;
            end
            if (!stat.left_zero && (!pend_ff || load_ram)) begin
               cmd.rd_issue = 1'b1;
               pend_in      = 1'b1;
               pend_fin_in  = stat.last_group;
               pend_end_in  = stat.last_group && copy_last_ff;
            end
            if (stat.left_zero && (!pend_ff || load_ram)) begin
               state_in = ST_IDLE;
            end
         end
      endcase

      out_valid_in = (out_valid_ff && !rsp_ready) || (cmd.out_sel != OUT_NONE);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LIT;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         pend_fin_ff  <= 1'b0;
         pend_end_ff  <= 1'b0;
         copy_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         pend_fin_ff  <= pend_fin_in;
         pend_end_ff  <= pend_end_in;
         copy_last_ff <= copy_last_in;
      end
   end

endmodule

>>> rtl/core/pattern_backref_unroller.sv
// top level of the back-reference unroller
//
// Compressed track bytes enter one per word on the req_ channel and are kept in
// a history ring of four interleaved banks. A literal byte, or an escaped 0xfe,
// gives one result word. The length byte of a marker starts a copy that reads
// all four banks at once and delivers up to four bytes per cycle while
// rsp_ready does not hold the output back; req_ready stays low until the copy
// is done. A new byte is taken only when the output register is empty or its
// word leaves in the same cycle. The ring comes up without clearing: the range
// checks keep every read inside bytes written in the current track.
module pattern_backref_unroller (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [2:0] rsp_byte_count,
   output logic       rsp_run_last,
   output logic       rsp_stream_end,
   output logic [1:0] rsp_error_code
);

   import pbu_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // parser and copy sequencer
   pbu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_last_in (req_last_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // counters, history ring and output word
   pbu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_data_byte  (req_data_byte),
      .rsp_out_byte0  (rsp_out_byte0),
      .rsp_out_byte1  (rsp_out_byte1),
      .rsp_out_byte2  (rsp_out_byte2),
      .rsp_out_byte3  (rsp_out_byte3),
      .rsp_byte_count (rsp_byte_count),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end),
      .rsp_error_code (rsp_error_code)
   );

endmodule
